@@ src/serial_record_deframer_unit_assert.svh @@
// Assertion macros for the serial record deframer.
// Included by modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef SERIAL_RECORD_DEFRAMER_UNIT_ASSERT_SVH
`define SERIAL_RECORD_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SRD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srd check failed");

// Next-cycle implication, disabled during reset
`define SRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srd check failed");

`endif

@@ src/srd_pkg.sv @@
// Shared types and constants for the serial record deframer.
// No dependencies; imported by every module of the block.
package srd_pkg;

    // Framing characters
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_CLOSE  = 8'h3C;
    localparam logic [7:0] C_CHAR_A = 8'h41;
    localparam logic [7:0] C_CHAR_B = 8'h42;

    // Frame lengths and positions
    localparam logic [10:0] LEN_SINGLE  = 11'd50;
    localparam logic [10:0] LEN_HEADER  = 11'd16;
    localparam logic [10:0] LEN_CHANNEL = 11'd36;
    localparam logic [10:0] TYPE_POS    = 11'd4;
    localparam logic [2:0]  CHANNELS    = 3'd6;

    // Pending byte limit
    localparam logic [10:0] LIMIT_MAX   = 11'd1024;

    typedef enum logic [2:0] {
        KIND_IGNORED  = 3'd0,
        KIND_SINGLE   = 3'd1,
        KIND_HEADER   = 3'd2,
        KIND_CHANNEL  = 3'd3,
        KIND_OVERFLOW = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [10:0] byte_index;
        logic        frame_end;
        t_kind       frame_kind;
        logic [2:0]  channel_slot;
        logic        set_complete;
    } t_result;

endpackage

@@ src/serial_record_deframer_unit.sv @@
// Top level of the serial record deframer: input register, frame core, result register.
// Depends on srd_pkg, srd_in_stage, srd_core and srd_out_stage.
//
//  channel   dir  tdata (low bit up)            tlast      tuser (low bit up)
//  s_axis    in   rx_byte[7:0]                  -          -
//  m_axis    out  payload_byte[7:0],            frame_end  frame_kind[2:0],
//                 byte_index[18:8], zero pad               channel_slot[5:3],
//                                                          set_complete[6], zero pad
//  cfg       in   pending_limit[10:0] on write enable
//
// One byte per cycle sustained while m_axis accepts; each byte passes from input transfer
// to result through the input register, then the result register after the frame core.
// Bytes that cause no result (hunt, CR LF, skipped byte) still pass the core.
// A stalled master side holds the result; the input register fills and s_axis_tready drops.
// Synchronous active-low reset returns the parser to hunting and the limit to 1024.
module serial_record_deframer_unit
    import srd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte[7:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // payload_byte[7:0], byte_index[18:8], zeros
    output logic        o_m_axis_tlast,
    output logic [7:0]  o_m_axis_tuser,   // frame_kind[2:0], channel_slot[5:3],
                                          // set_complete[6], zero
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);

    logic       out_ready;
    logic       step;
    logic [7:0] in_byte;
    logic       res_vld;
    t_result    res;
    t_result    m_res;

    srd_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_byte       (i_s_axis_tdata),
        .i_down_ready (out_ready),
        .o_step       (step),
        .o_byte       (in_byte)
    );

    srd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_vld   (res_vld),
        .o_res       (res)
    );

    srd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (step && res_vld),
        .i_res   (res),
        .o_ready (out_ready),
        .o_vld   (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (m_res)
    );

    // Pack the result onto the stream fields
    assign o_m_axis_tdata = {5'd0, m_res.byte_index, m_res.payload_byte};
    assign o_m_axis_tlast = m_res.frame_end;
    assign o_m_axis_tuser = {1'b0, m_res.set_complete, m_res.channel_slot,
                             m_res.frame_kind};

endmodule

@@ src/srd_in_stage.sv @@
// Input register of the serial record deframer.
// Depends on srd_pkg (imported for house consistency).
module srd_in_stage
    import srd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_down_ready,   // result stage can take a transfer
    output logic       o_step,         // held byte is processed this cycle
    output logic [7:0] o_byte
);

    logic       r_vld;
    logic [7:0] r_byte;

    assign o_step  = r_vld && i_down_ready;
    assign o_ready = !r_vld || i_down_ready;
    assign o_byte  = r_byte;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Byte holding register
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

@@ src/srd_core.sv @@
// Frame state machine, counters and classifier of the serial record deframer.
// Depends on srd_pkg and serial_record_deframer_unit_assert.svh.
`include "serial_record_deframer_unit_assert.svh"

module srd_core
    import srd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    output logic        o_res_vld,
    output t_result     o_res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_CR,
        PH_SKIP,
        PH_DATA
    } t_phase;

    logic [10:0] r_limit;
    t_phase      r_phase,   n_phase;
    logic [10:0] r_payload, n_payload;
    logic [7:0]  r_type,    n_type;
    logic [10:0] r_pending, n_pending;
    logic        r_open,    n_open;
    logic [2:0]  r_chans,   n_chans;

    logic [10:0] lim;
    logic        is_head;
    logic [2:0]  chans_inc;

    // Effective limit: values above the maximum clamp to it
    assign lim       = (r_limit > LIMIT_MAX) ? LIMIT_MAX : r_limit;
    assign is_head   = (r_payload == LEN_HEADER) && (r_type == C_CHAR_B);
    assign chans_inc = r_chans + 3'd1;

    // Next state and result for the byte in the input register
    always_comb begin
        n_phase   = r_phase;
        n_payload = r_payload;
        n_type    = r_type;
        n_pending = r_pending + 11'd1;
        n_open    = r_open;
        n_chans   = r_chans;
        o_res_vld = 1'b0;
        o_res     = '{payload_byte: 8'd0, byte_index: 11'd0, frame_end: 1'b0,
                      frame_kind: KIND_IGNORED, channel_slot: 3'd0,
                      set_complete: 1'b0};

        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == C_CR) begin
                    n_phase = PH_CR;
                end
            end
            PH_CR: begin
                if (i_byte == C_LF) begin
                    n_phase = PH_SKIP;
                end else if (i_byte != C_CR) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_SKIP: begin
                n_phase   = PH_DATA;
                n_payload = 11'd0;
                n_type    = 8'd0;
            end
            PH_DATA: begin
                if (i_byte == C_CLOSE) begin
                    o_res_vld        = 1'b1;
                    o_res.frame_end  = 1'b1;
                    o_res.byte_index = r_payload;
                    // classify the closed frame
                    priority if (!r_open) begin
                        if (r_payload == LEN_SINGLE && r_type == C_CHAR_A) begin
                            o_res.frame_kind = KIND_SINGLE;
                        end else if (is_head) begin
                            o_res.frame_kind = KIND_HEADER;
                            n_open           = 1'b1;
                            n_chans          = 3'd0;
                        end
                    end else if (is_head) begin
                        o_res.frame_kind = KIND_HEADER;
                        n_chans          = 3'd0;
                    end else if (r_payload == LEN_CHANNEL && r_chans < CHANNELS) begin
                        o_res.frame_kind   = KIND_CHANNEL;
                        o_res.channel_slot = chans_inc;
                        n_chans            = chans_inc;
                        if (chans_inc == CHANNELS) begin
                            o_res.set_complete = 1'b1;
                            n_open             = 1'b0;
                        end
                    end else begin
                        o_res.frame_kind = KIND_IGNORED;
                    end
                    n_phase   = PH_HUNT;
                    n_payload = 11'd0;
                    n_type    = 8'd0;
                    n_pending = 11'd0;
                end else begin
                    if (r_payload == TYPE_POS) begin
                        n_type = i_byte;
                    end
                    o_res_vld          = 1'b1;
                    o_res.payload_byte = i_byte;
                    o_res.byte_index   = r_payload;
                    n_payload          = r_payload + 11'd1;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        // Too many unconsumed bytes: drop everything and report
        if (n_pending > lim) begin
            n_phase   = PH_HUNT;
            n_payload = 11'd0;
            n_type    = 8'd0;
            n_pending = 11'd0;
            n_open    = 1'b0;
            n_chans   = 3'd0;
            o_res_vld = 1'b1;
            o_res     = '{payload_byte: 8'd0, byte_index: 11'd0, frame_end: 1'b1,
                          frame_kind: KIND_OVERFLOW, channel_slot: 3'd0,
                          set_complete: 1'b0};
        end
    end

    // State and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_MAX;
            r_phase   <= PH_HUNT;
            r_payload <= 11'd0;
            r_type    <= 8'd0;
            r_pending <= 11'd0;
            r_open    <= 1'b0;
            r_chans   <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_step) begin
                r_phase   <= n_phase;
                r_payload <= n_payload;
                r_type    <= n_type;
                r_pending <= n_pending;
                r_open    <= n_open;
                r_chans   <= n_chans;
            end
        end
    end

    // An open set never has all six channels counted
    `SRD_ASSERT_SAME(a_open_chans, r_open, r_chans < CHANNELS)
    // Pending count stays within the largest limit
    `SRD_ASSERT_SAME(a_pending_max, 1'b1, r_pending <= LIMIT_MAX)
    // Every frame close or overflow leaves the parser hunting with nothing pending
    `SRD_ASSERT_NEXT(a_end_clears, i_step && o_res_vld && o_res.frame_end,
                     r_phase == PH_HUNT && r_pending == 11'd0 && r_payload == 11'd0)
    // Overflow also drops the open set
    `SRD_ASSERT_NEXT(a_ovf_drops_set,
                     i_step && o_res_vld && o_res.frame_kind == KIND_OVERFLOW,
                     !r_open && r_chans == 3'd0)

endmodule

@@ src/srd_out_stage.sv @@
// Result register of the serial record deframer.
// Depends on srd_pkg for the result type.
module srd_out_stage
    import srd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_result i_res,
    output logic    o_ready,    // can take a result this cycle
    output logic    o_vld,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_vld;
    t_result r_res;

    assign o_ready = !r_vld || i_ready;
    assign o_vld   = r_vld;
    assign o_res   = r_res;

    // Valid flag: refilled whenever the held result is gone or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    // Result holding register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_res <= i_res;
        end
    end

endmodule

@@ tb/tb_serial_record_deframer_unit.sv @@
// Self-checking testbench for serial_record_deframer_unit: drives byte streams with random
// gaps and output stalls, predicts every frame result and checks each field.
// Depends on srd_pkg and the block's RTL only.
module tb_serial_record_deframer_unit;
    import srd_pkg::*;

    // Parser phases of the predictor
    typedef enum logic [1:0] {
        SCAN_CR,
        SCAN_LF,
        SKIP_ONE,
        IN_PAYLOAD
    } t_scan;

    localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
    localparam int PHASE_BYTES = 20;    // random bytes per limit setting, at least

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [7:0]  o_m_axis_tuser;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;

    // Predictor state
    t_scan       scan;
    logic [10:0] pay_count;
    logic [7:0]  type_char;
    logic [10:0] held_bytes;
    logic        set_open;
    logic [2:0]  chans;
    logic [10:0] limit_reg;

    t_result     frame_out_q[$];   // predicted results, oldest first
    int          mismatch_count;
    int          bytes_sent;
    int          stall_cycles;
    int          hold_cycles;      // long receiver hold-off request
    bit          sender_gaps;
    bit          rx_stalls;

    serial_record_deframer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // rx_byte[7:0]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // payload_byte[7:0], byte_index[18:8], zeros
        .o_m_axis_tlast  (o_m_axis_tlast),   // frame_end
        .o_m_axis_tuser  (o_m_axis_tuser),   // frame_kind[2:0], channel_slot[5:3],
                                             // set_complete[6], zero
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Parser state back to its idle values; the limit register is kept
    function automatic void clear_state();
        scan       = SCAN_CR;
        pay_count  = '0;
        type_char  = '0;
        held_bytes = '0;
        set_open   = 1'b0;
        chans      = '0;
    endfunction

    // Advance the predictor by one byte; returns 1 when the byte yields a result
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        logic [10:0] lim;
        logic [10:0] len;
        bit          has;
        bit          is_head;
        lim = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;
        has = 1'b0;
        r   = '0;
        held_bytes++;
        case (scan)
            SCAN_CR: begin
                if (b == C_CR) scan = SCAN_LF;
            end
            SCAN_LF: begin
                if (b == C_LF) scan = SKIP_ONE;
                else if (b != C_CR) scan = SCAN_CR;
            end
            SKIP_ONE: begin
                scan      = IN_PAYLOAD;
                pay_count = '0;
                type_char = '0;
            end
            default: begin
                if (b == C_CLOSE) begin
                    // frame close: classify by length and type character
                    len          = pay_count;
                    is_head      = (len == LEN_HEADER) && (type_char == C_CHAR_B);
                    r.byte_index = len;
                    r.frame_end  = 1'b1;
                    r.frame_kind = KIND_IGNORED;
                    if (!set_open) begin
                        if (len == LEN_SINGLE && type_char == C_CHAR_A) begin
                            r.frame_kind = KIND_SINGLE;
                        end else if (is_head) begin
                            r.frame_kind = KIND_HEADER;
                            set_open     = 1'b1;
                            chans        = '0;
                        end
                    end else if (is_head) begin
                        r.frame_kind = KIND_HEADER;
                        chans        = '0;
                    end else if (len == LEN_CHANNEL && chans < CHANNELS) begin
                        chans++;
                        r.frame_kind   = KIND_CHANNEL;
                        r.channel_slot = chans;
                        if (chans == CHANNELS) begin
                            r.set_complete = 1'b1;
                            set_open       = 1'b0;
                        end
                    end
                    scan       = SCAN_CR;
                    pay_count  = '0;
                    type_char  = '0;
                    held_bytes = '0;
                end else begin
                    if (pay_count == TYPE_POS) type_char = b;
                    r.payload_byte = b;
                    r.byte_index   = pay_count;
                    pay_count++;
                end
                has = 1'b1;
            end
        endcase
        // overflow replaces any result of this byte
        if (held_bytes > lim) begin
            clear_state();
            r            = '0;
            r.frame_end  = 1'b1;
            r.frame_kind = KIND_OVERFLOW;
            has          = 1'b1;
        end
        return has;
    endfunction

    // One input transfer, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b);
        t_result r;
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (deframe_byte(b, r)) frame_out_q.push_back(r);
        bytes_sent++;
    endtask

    // Random bytes that never start a frame
    task automatic send_noise(input int n);
        logic [7:0] b;
        repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == C_CR);
            send_byte(b);
        end
    endtask

    // CR LF, one dropped byte, payload with tchar at the type position, optional close
    task automatic send_frame(input int len, input logic [7:0] tchar, input bit closed);
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) send_byte(C_CR);
        send_byte(C_CR);
        send_byte(C_LF);
        send_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++) begin
            if (i == int'(TYPE_POS)) b = tchar;
            else do b = 8'($urandom_range(0, 255)); while (b == C_CLOSE);
            send_byte(b);
        end
        if (closed) send_byte(C_CLOSE);
    endtask

    // Stop sending, let every predicted result drain, then let the pipe settle
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (frame_out_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [10:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_reg = v;
    endtask

    // Hunt, repeated CR, broken CR, dropped close, CR LF in payload, short frames
    task automatic test_directed_framing();
        logic [7:0] seq[];
        seq = '{8'h00, 8'hFF, C_CR, 8'h58, C_LF, C_CR, C_CR, C_LF, C_CLOSE,
                8'h00, 8'hFF, C_CR, C_LF, C_CLOSE, C_CR, C_LF, 8'h20, C_CLOSE};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Classification with no set open
    task automatic test_frame_kinds();
        send_frame(50, C_CHAR_A, 1'b1);
        send_frame(16, C_CHAR_A, 1'b1);
        send_frame(50, C_CHAR_B, 1'b1);
        send_frame(36, C_CHAR_B, 1'b1);   // channel record outside a set
        send_frame(51, C_CHAR_A, 1'b1);
        send_frame(4, C_CHAR_A, 1'b1);
    endtask

    // Header, channel numbering, restarts and completion
    task automatic test_set_sequencing();
        send_frame(16, C_CHAR_B, 1'b1);
        repeat (3) send_frame(36, 8'($urandom_range(0, 255)), 1'b1);
        send_frame(50, C_CHAR_A, 1'b1);   // single record inside a set
        send_frame(16, C_CHAR_B, 1'b1);   // header restarts the count
        send_frame(37, C_CHAR_B, 1'b1);
        repeat (6) send_frame(36, 8'($urandom_range(0, 255)), 1'b1);
        send_frame(36, C_CHAR_A, 1'b1);   // after completion
        send_frame(16, C_CHAR_B, 1'b1);
        repeat (2) send_frame(36, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Limit register extremes, including values outside the documented range
    task automatic test_limit_extremes();
        write_limit(11'h7FF);             // acts as the maximum
        send_frame(1030, C_CHAR_A, 1'b0);
        send_byte(C_CLOSE);
        write_limit(11'd0);
        send_frame(2, C_CHAR_A, 1'b1);
        write_limit(11'd10);
        send_frame(20, C_CHAR_A, 1'b1);
        send_frame(3, C_CHAR_A, 1'b1);
        write_limit(11'd64);
        send_frame(50, C_CHAR_A, 1'b1);
        send_noise(10);
        send_frame(50, C_CHAR_A, 1'b1);   // hunt bytes bring the close to the limit, past it with the extra CR
        send_frame(16, C_CHAR_B, 1'b1);
        write_limit(LIMIT_MAX);
    endtask

    // Receiver holds off while the sender keeps offering bytes
    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        hold_cycles = 80;
        send_frame(36, C_CHAR_B, 1'b1);
        send_frame(36, C_CHAR_A, 1'b1);
        sender_gaps = 1'b1;
    endtask

    // Mostly well-formed frames and sets with random content, plus noise and broken frames
    task automatic test_random_traffic();
        logic [10:0] limits[5];
        logic [7:0]  b;
        int          start;
        limits = '{LIMIT_MAX, 11'($urandom_range(64, 1024)), 11'd64,
                   11'($urandom_range(0, 2047)), 11'd200};
        for (int p = 0; p < 5; p++) begin
            write_limit(limits[p]);
            if (p == 4) begin
                sender_gaps = 1'b0;
                rx_stalls   = 1'b0;
            end else begin
                sender_gaps = ($urandom_range(0, 3) != 0);
                rx_stalls   = ($urandom_range(0, 3) != 0);
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) begin
                if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 6));
                case ($urandom_range(0, 9))
                    0, 1: begin
                        send_frame(16, C_CHAR_B, 1'b1);
                        repeat (6) begin
                            if ($urandom_range(0, 7) == 0)
                                send_frame($urandom_range(0, 60),
                                           8'($urandom_range(0, 255)), 1'b1);
                            send_frame(36, 8'($urandom_range(0, 255)), 1'b1);
                        end
                    end
                    2: send_frame(50, C_CHAR_A, 1'b1);
                    3: send_frame(16, C_CHAR_B, 1'b1);
                    4: send_frame(36, 8'($urandom_range(0, 255)), 1'b1);
                    5: send_frame($urandom_range(0, 60), 8'($urandom_range(0, 255)), 1'b1);
                    6: send_frame($urandom_range(0, 20), 8'($urandom_range(0, 255)), 1'b0);
                    7: begin
                        // CR followed by neither LF nor CR
                        send_byte(C_CR);
                        do b = 8'($urandom_range(0, 255)); while (b == C_LF || b == C_CR);
                        send_byte(b);
                    end
                    8: send_frame($urandom_range(0, 1) ? 16 : 50,
                                  $urandom_range(0, 1) ? C_CHAR_A : C_CHAR_B, 1'b1);
                    default: send_frame(LEN_CHANNEL + $urandom_range(0, 2) - 1,
                                        8'($urandom_range(0, 255)), 1'b1);
                endcase
            end
        end
    endtask

    // Receiver: random stall bursts and the long hold-off on request
    initial begin : receiver
        int n;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (mismatch_count <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    // Compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.payload_byte = o_m_axis_tdata[7:0];
            got.byte_index   = o_m_axis_tdata[18:8];
            got.frame_end    = o_m_axis_tlast;
            got.frame_kind   = t_kind'(o_m_axis_tuser[2:0]);
            got.channel_slot = o_m_axis_tuser[5:3];
            got.set_complete = o_m_axis_tuser[6];
            if (frame_out_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 40)
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = frame_out_q.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (got.payload_byte !== want.payload_byte)
                        report_field("payload_byte", 32'(want.payload_byte),
                                     32'(got.payload_byte));
                    if (got.byte_index !== want.byte_index)
                        report_field("byte_index", 32'(want.byte_index),
                                     32'(got.byte_index));
                    if (got.frame_end !== want.frame_end)
                        report_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
                    if (got.frame_kind !== want.frame_kind)
                        report_field("frame_kind", 32'(want.frame_kind),
                                     32'(got.frame_kind));
                    if (got.channel_slot !== want.channel_slot)
                        report_field("channel_slot", 32'(want.channel_slot),
                                     32'(got.channel_slot));
                    if (got.set_complete !== want.set_complete)
                        report_field("set_complete", 32'(want.set_complete),
                                     32'(got.set_complete));
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("serial_record_deframer_unit test failed");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        mismatch_count  = 0;
        bytes_sent      = 0;
        stall_cycles    = 0;
        hold_cycles     = 0;
        sender_gaps     = 1'b1;
        rx_stalls       = 1'b1;
        limit_reg       = LIMIT_MAX;
        clear_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_framing();
        test_frame_kinds();
        test_set_sequencing();
        test_limit_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("serial_record_deframer_unit test passed");
        end else begin
            $display("serial_record_deframer_unit test failed");
        end
        $finish;
    end

endmodule

@@ serial_record_deframer_unit.f @@
+incdir+src
src/srd_pkg.sv
src/srd_in_stage.sv
src/srd_core.sv
src/srd_out_stage.sv
src/serial_record_deframer_unit.sv
tb/tb_serial_record_deframer_unit.sv
